@@ sv/pon_pkg.sv @@
// Shared constants, types and state codes for the polygon orientation normaliser.
// No dependencies; imported by pon_cross, the top level and the bench modules.
`default_nettype none

package pon_pkg;

    localparam int MAX_VERTS  = 16;
    localparam int COORD_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_VERTS);
    localparam int CNT_W      = $clog2(MAX_VERTS + 1);
    localparam int SRC_W      = 4;
    localparam int TOTAL_W    = 16;
    localparam int VTX_W      = 2 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int MIN_VERTS  = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0]
    {
        VX_A,
        VX_B,
        VX_C
    } vsel_t;

    typedef struct packed
    {
        logic  load;
        vsel_t sel;
        logic  start;
    } cross_ctl_t;

    typedef struct packed
    {
        logic done;
        logic positive;
    } cross_sts_t;

    typedef enum logic [3:0]
    {
        CS_IDLE,
        CS_DX1,
        CS_DY2,
        CS_DX2,
        CS_DY1,
        CS_MUL_P,
        CS_MUL_Q,
        CS_DIFF,
        CS_DONE
    } cross_step_t;

    typedef enum logic [3:0]
    {
        ST_LOAD,
        ST_CHECK,
        ST_BAD,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_LD_C,
        ST_WAIT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

`default_nettype wire

@@ sv/pon_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module pon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/pon_cross.sv @@
// Exact 2D cross product sign, (B-A)x(C-A) > 0, on one shared subtractor and
// one shared multiplier stepped by a small sequencer. Depends on pon_pkg.
`default_nettype none

module pon_cross (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pon_pkg::cross_ctl_t ctl,
    input  wire pon_pkg::coord_t    vx,
    input  wire pon_pkg::coord_t    vy,
    output pon_pkg::cross_sts_t     sts
);

    import pon_pkg::*;

    cross_step_t step_reg, step_next;

    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy2_reg, dx2_reg, dy1_reg;
    logic signed [PROD_W-1:0] p_reg, q_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [ACC_W-1:0]  sub_a, sub_b, sub_res;
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_res;

    function automatic logic signed [ACC_W-1:0] sx(input coord_t v);
        sx = {{(ACC_W - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // shared subtractor
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (step_reg)
            CS_DX1:
            begin
                sub_a = sx(bx_reg);
                sub_b = sx(ax_reg);
            end
            CS_DY2:
            begin
                sub_a = sx(cy_reg);
                sub_b = sx(ay_reg);
            end
            CS_DX2:
            begin
                sub_a = sx(cx_reg);
                sub_b = sx(ax_reg);
            end
            CS_DY1:
            begin
                sub_a = sx(by_reg);
                sub_b = sx(ay_reg);
            end
            CS_DIFF:
            begin
                sub_a = {p_reg[PROD_W-1], p_reg};
                sub_b = {q_reg[PROD_W-1], q_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_res = sub_a - sub_b;
    end

    // shared multiplier
    always_comb
    begin
        if (step_reg == CS_MUL_Q)
        begin
            mul_a = dx2_reg;
            mul_b = dy1_reg;
        end
        else
        begin
            mul_a = dx1_reg;
            mul_b = dy2_reg;
        end
        mul_res = mul_a * mul_b;
    end

    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            CS_IDLE:  if (ctl.start) step_next = CS_DX1;
            CS_DX1:   step_next = CS_DY2;
            CS_DY2:   step_next = CS_DX2;
            CS_DX2:   step_next = CS_DY1;
            CS_DY1:   step_next = CS_MUL_P;
            CS_MUL_P: step_next = CS_MUL_Q;
            CS_MUL_Q: step_next = CS_DIFF;
            CS_DIFF:  step_next = CS_DONE;
            CS_DONE:  step_next = CS_IDLE;
            default:  step_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= CS_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            unique case (ctl.sel)
                VX_A:
                begin
                    ax_reg <= vx;
                    ay_reg <= vy;
                end
                VX_B:
                begin
                    bx_reg <= vx;
                    by_reg <= vy;
                end
                default:
                begin
                    cx_reg <= vx;
                    cy_reg <= vy;
                end
            endcase
        end
        if (step_reg == CS_DX1)   dx1_reg <= sub_res[DIFF_W-1:0];
        if (step_reg == CS_DY2)   dy2_reg <= sub_res[DIFF_W-1:0];
        if (step_reg == CS_DX2)   dx2_reg <= sub_res[DIFF_W-1:0];
        if (step_reg == CS_DY1)   dy1_reg <= sub_res[DIFF_W-1:0];
        if (step_reg == CS_MUL_P) p_reg   <= mul_res;
        if (step_reg == CS_MUL_Q) q_reg   <= mul_res;
        if (step_reg == CS_DIFF)  acc_reg <= sub_res;
    end

    assign sts.done     = (step_reg == CS_DONE);
    assign sts.positive = !acc_reg[ACC_W-1] && (acc_reg != '0);

endmodule

`default_nettype wire

@@ sv/polygon_orientation_normalizer.sv @@
// Top level of the polygon orientation normaliser: load sequencer, vertex store,
// output register. Depends on pon_pkg, pon_ram and pon_cross.
//
// Input channel (in_valid/in_stall): one vertex word per handshake, vertex_x,
// vertex_y signed Q16.16, last_vertex marks the end of the polygon. Vertices
// load at one per cycle while the block is in its load phase.
// Output channel (out_valid/out_stall): one word per vertex in output order,
// with last_out on the final one; a rejected polygon (fewer than 3 or more
// than 16 vertices) gives a single word with bad_polygon set.
// After the last vertex: a check, store reads of the three chosen vertices, the
// shared cross product unit, then for each emitted vertex a store read followed
// by an output register load.
// in_stall is high from the last vertex until the final result word has been
// loaded into the output register, so a waiting final word does not hold off
// the next polygon. A stalled receiver freezes emission at the output register.
// Reset (rst_n low, asynchronous) empties the load state, the output valid flag
// and the reversal count; the output data fields and the vertex store are not cleared.
`default_nettype none

module polygon_orientation_normalizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pon_pkg::coord_t               vertex_x,
    input  wire pon_pkg::coord_t               vertex_y,
    input  wire logic                          last_vertex,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pon_pkg::coord_t                    out_x,
    output pon_pkg::coord_t                    out_y,
    output logic [pon_pkg::SRC_W-1:0]          source_index,
    output logic                               reversed,
    output logic                               bad_polygon,
    output logic                               last_out,
    output logic [pon_pkg::TOTAL_W-1:0]        reoriented_total
);

    import pon_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   low_idx_reg, low_idx_next;
    coord_t             low_x_reg, low_x_next;
    coord_t             low_y_reg, low_y_next;
    logic               rev_reg, rev_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;

    coord_t             out_x_reg, out_x_next;
    coord_t             out_y_reg, out_y_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic               rev_out_reg, rev_out_next;
    logic               bad_reg, bad_next;
    logic               last_reg, last_next;
    logic [TOTAL_W-1:0] tot_out_reg, tot_out_next;
    logic               out_load;

    logic               in_acc;
    logic               can_load;
    logic [CNT_W-1:0]   n_m1;
    logic [CNT_W-1:0]   src_full;
    logic [IDX_W-1:0]   ia, ib, ic;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [VTX_W-1:0]   ram_rdata;
    coord_t             rd_x, rd_y;

    cross_ctl_t         xctl;
    cross_sts_t         xsts;

    pon_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({vertex_x, vertex_y}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[VTX_W-1:COORD_BITS];
    assign rd_y = ram_rdata[COORD_BITS-1:0];

    pon_cross u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (xctl),
        .vx    (rd_x),
        .vy    (rd_y),
        .sts   (xsts)
    );

    assign in_acc   = in_valid && (state_reg == ST_LOAD);
    assign can_load = !out_valid_reg || !out_stall;
    assign ram_we   = in_acc && (count_reg < CNT_W'(MAX_VERTS));

    // neighbour indices of the chosen vertex; triangles use 0,1,2
    always_comb
    begin
        n_m1 = count_reg - CNT_W'(1);
        if (count_reg == CNT_W'(MIN_VERTS))
        begin
            ia = IDX_W'(0);
            ib = IDX_W'(1);
            ic = IDX_W'(2);
        end
        else
        begin
            ib = low_idx_reg;
            ia = (low_idx_reg == '0) ? n_m1[IDX_W-1:0] : low_idx_reg - IDX_W'(1);
            ic = (CNT_W'(low_idx_reg) == n_m1) ? IDX_W'(0) : low_idx_reg + IDX_W'(1);
        end
        src_full = rev_reg ? (n_m1 - CNT_W'(k_reg)) : CNT_W'(k_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        low_idx_next   = low_idx_reg;
        low_x_next     = low_x_reg;
        low_y_next     = low_y_reg;
        rev_next       = rev_reg;
        k_next         = k_reg;
        total_next     = total_reg;
        out_load       = 1'b0;
        out_x_next     = rd_x;
        out_y_next     = rd_y;
        src_next       = SRC_W'(src_full[IDX_W-1:0]);
        rev_out_next   = rev_reg;
        bad_next       = 1'b0;
        last_next      = (CNT_W'(k_reg) == n_m1);
        tot_out_next   = total_reg;
        ram_re         = 1'b0;
        ram_raddr      = ia;
        xctl.load      = 1'b0;
        xctl.sel       = VX_A;
        xctl.start     = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CNT_W'(MAX_VERTS))
                    begin
                        if ((count_reg == '0) || (vertex_y < low_y_reg) ||
                            ((vertex_y == low_y_reg) && (vertex_x >= low_x_reg)))
                        begin
                            low_idx_next = count_reg[IDX_W-1:0];
                            low_x_next   = vertex_x;
                            low_y_next   = vertex_y;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_vertex)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (ovf_reg || (count_reg < CNT_W'(MIN_VERTS)))
                    state_next = ST_BAD;
                else
                    state_next = ST_RD_A;
            end
            ST_BAD:
            begin
                if (can_load)
                begin
                    out_load     = 1'b1;
                    out_x_next   = '0;
                    out_y_next   = '0;
                    src_next     = '0;
                    rev_out_next = 1'b0;
                    bad_next     = 1'b1;
                    last_next    = 1'b1;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    low_idx_next = '0;
                    low_x_next   = '0;
                    low_y_next   = '0;
                    state_next   = ST_LOAD;
                end
            end
            ST_RD_A:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ia;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ib;
                xctl.load  = 1'b1;
                xctl.sel   = VX_A;
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ic;
                xctl.load  = 1'b1;
                xctl.sel   = VX_B;
                state_next = ST_LD_C;
            end
            ST_LD_C:
            begin
                xctl.load  = 1'b1;
                xctl.sel   = VX_C;
                xctl.start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (xsts.done)
                begin
                    rev_next = xsts.positive;
                    if (xsts.positive && (total_reg != '1))
                        total_next = total_reg + TOTAL_W'(1);
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = src_full[IDX_W-1:0];
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    if (CNT_W'(k_reg) == n_m1)
                    begin
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        low_idx_next = '0;
                        low_x_next   = '0;
                        low_y_next   = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            low_idx_reg   <= '0;
            low_x_reg     <= '0;
            low_y_reg     <= '0;
            rev_reg       <= 1'b0;
            k_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            low_idx_reg   <= low_idx_next;
            low_x_reg     <= low_x_next;
            low_y_reg     <= low_y_next;
            rev_reg       <= rev_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            src_reg     <= src_next;
            rev_out_reg <= rev_out_next;
            bad_reg     <= bad_next;
            last_reg    <= last_next;
            tot_out_reg <= tot_out_next;
        end
    end

    assign in_stall         = (state_reg != ST_LOAD);
    assign out_valid        = out_valid_reg;
    assign out_x            = out_x_reg;
    assign out_y            = out_y_reg;
    assign source_index     = src_reg;
    assign reversed         = rev_out_reg;
    assign bad_polygon      = bad_reg;
    assign last_out         = last_reg;
    assign reoriented_total = tot_out_reg;

endmodule

`default_nettype wire

@@ bench/pon_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the polygon orientation normaliser: watches both channels, predicts the
// output words of each face and compares them field by field. Depends on pon_pkg.

module pon_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  pon_pkg::coord_t               vertex_x,
    input  pon_pkg::coord_t               vertex_y,
    input  logic                          last_vertex,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  pon_pkg::coord_t               out_x,
    input  pon_pkg::coord_t               out_y,
    input  logic [pon_pkg::SRC_W-1:0]     source_index,
    input  logic                          reversed,
    input  logic                          bad_polygon,
    input  logic                          last_out,
    input  logic [pon_pkg::TOTAL_W-1:0]   reoriented_total,
    output int                            errors,
    output int                            pending
);

    import pon_pkg::*;

    typedef struct packed
    {
        coord_t               x;
        coord_t               y;
        logic [SRC_W-1:0]     src;
        logic                 rev;
        logic                 bad;
        logic                 last;
        logic [TOTAL_W-1:0]   total;
    } face_word_t;

    coord_t               vx_store [MAX_VERTS];
    coord_t               vy_store [MAX_VERTS];
    logic [CNT_W-1:0]     n_loaded;
    logic [IDX_W-1:0]     low_idx;
    coord_t               low_x;
    coord_t               low_y;
    logic                 too_many;
    logic [TOTAL_W-1:0]   flip_count;
    face_word_t           face_words [$];
    face_word_t           want;
    int                   n_fail;

    // exact sign of (B-A)x(C-A)
    function automatic logic turns_left(input int ia, input int ib, input int ic);
        logic signed [ACC_W-1:0] bx, by, cx, cy, area;
        bx = vx_store[ib] - vx_store[ia];
        by = vy_store[ib] - vy_store[ia];
        cx = vx_store[ic] - vx_store[ia];
        cy = vy_store[ic] - vy_store[ia];
        area = bx * cy - cx * by;
        return area > 0;
    endfunction

    task automatic take_vertex(input coord_t x, input coord_t y, input logic last);
        face_word_t w;
        logic       flip;
        int         n, s, ia, ib, ic;
        if (n_loaded < MAX_VERTS) begin
            if (n_loaded == 0 || y < low_y || (y == low_y && x >= low_x)) begin
                low_idx = n_loaded[IDX_W-1:0];
                low_x   = x;
                low_y   = y;
            end
            vx_store[n_loaded] = x;
            vy_store[n_loaded] = y;
            n_loaded++;
        end
        else
        begin
            too_many = 1'b1;
        end
        if (!last)
            return;

        n = n_loaded;
        if (too_many || n < MIN_VERTS) begin
            w       = '0;
            w.bad   = 1'b1;
            w.last  = 1'b1;
            w.total = flip_count;
            face_words = {face_words, w};
        end
        else
        begin
            if (n == MIN_VERTS) begin
                flip = turns_left(0, 1, 2);
            end
            else
            begin
                ib   = low_idx;
                ia   = (ib == 0) ? n - 1 : ib - 1;
                ic   = (ib == n - 1) ? 0 : ib + 1;
                flip = turns_left(ia, ib, ic);
            end
            if (flip && flip_count != '1)
                flip_count++;
            for (int k = 0; k < n; k++) begin
                s       = flip ? n - 1 - k : k;
                w.x     = vx_store[s];
                w.y     = vy_store[s];
                w.src   = s[SRC_W-1:0];
                w.rev   = flip;
                w.bad   = 1'b0;
                w.last  = (k == n - 1);
                w.total = flip_count;
                face_words = {face_words, w};
            end
        end
        n_loaded = '0;
        low_idx  = '0;
        low_x    = '0;
        low_y    = '0;
        too_many = 1'b0;
    endtask

    task automatic check_field(input string field, input logic [COORD_BITS-1:0] exp_v,
                               input logic [COORD_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 'h%0h, got 'h%0h", field, exp_v, act_v);
            n_fail++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            n_loaded   = '0;
            low_idx    = '0;
            low_x      = '0;
            low_y      = '0;
            too_many   = 1'b0;
            flip_count = '0;
            n_fail     = 0;
            face_words.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall) begin
                if (face_words.size() == 0) begin
                    $error("unexpected word: out_x 'h%0h out_y 'h%0h source_index %0d",
                           out_x, out_y, source_index);
                    n_fail++;
                end
                else
                begin
                    want = face_words.pop_front();
                    check_field("out_x", want.x, out_x);
                    check_field("out_y", want.y, out_y);
                    check_field("source_index", want.src, source_index);
                    check_field("reversed", want.rev, reversed);
                    check_field("bad_polygon", want.bad, bad_polygon);
                    check_field("last_out", want.last, last_out);
                    check_field("reoriented_total", want.total, reoriented_total);
                end
            end
            if (in_valid && !in_stall)
                take_vertex(vertex_x, vertex_y, last_vertex);
            errors  <= n_fail;
            pending <= face_words.size();
        end
    end

endmodule

@@ bench/tb_polygon_orientation_normalizer.sv @@
`timescale 1ns / 1ps
// Testbench top for the polygon orientation normaliser: clock, reset, face stimulus and
// receiver stalls; checking is done by pon_checker. Depends on pon_pkg and the block.

module tb_polygon_orientation_normalizer;
    import pon_pkg::*;

    localparam int     CYCLE_LIMIT  = 100000;
    localparam int     RANDOM_WORDS = 150;
    localparam coord_t C_MIN        = coord_t'(32'h8000_0000);
    localparam coord_t C_MAX        = coord_t'(32'h7fff_ffff);

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    coord_t               vertex_x    = '0;
    coord_t               vertex_y    = '0;
    logic                 last_vertex = 1'b0;
    logic                 out_stall   = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    coord_t               out_x;
    coord_t               out_y;
    logic [SRC_W-1:0]     source_index;
    logic                 reversed;
    logic                 bad_polygon;
    logic                 last_out;
    logic [TOTAL_W-1:0]   reoriented_total;
    int                   errors;
    int                   pending;
    int                   cycle_count = 0;
    int                   in_quiet    = 0;
    int                   out_quiet   = 0;
    coord_t               face_x [$];
    coord_t               face_y [$];

    polygon_orientation_normalizer u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .vertex_x         (vertex_x),
        .vertex_y         (vertex_y),
        .last_vertex      (last_vertex),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_x            (out_x),
        .out_y            (out_y),
        .source_index     (source_index),
        .reversed         (reversed),
        .bad_polygon      (bad_polygon),
        .last_out         (last_out),
        .reoriented_total (reoriented_total)
    );

    pon_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .vertex_x         (vertex_x),
        .vertex_y         (vertex_y),
        .last_vertex      (last_vertex),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_x            (out_x),
        .out_y            (out_y),
        .source_index     (source_index),
        .reversed         (reversed),
        .bad_polygon      (bad_polygon),
        .last_out         (last_out),
        .reoriented_total (reoriented_total),
        .errors           (errors),
        .pending          (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_vertex(input coord_t x, input coord_t y, input logic last);
        int gap;
        if (in_quiet > 0) begin
            in_quiet--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                in_quiet = $urandom_range(4, 24);
            gap = $urandom_range(0, 12);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        vertex_x    <= x;
        vertex_y    <= y;
        last_vertex <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_face();
        int n;
        n = face_x.size();
        for (int i = 0; i < n; i++)
            push_vertex(face_x[i], face_y[i], i == n - 1);
        face_x.delete();
        face_y.delete();
    endtask

    function automatic coord_t pick_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 6)) - 3);
            default:
                case ($urandom_range(0, 4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    3: return '1;
                    default: return coord_t'($urandom);
                endcase
        endcase
    endfunction

    task automatic random_face(output int n);
        int kind, xmode, ymode;
        kind = $urandom_range(0, 99);
        if (kind < 8)
            n = $urandom_range(1, MIN_VERTS - 1);
        else if (kind < 14)
            n = $urandom_range(MAX_VERTS + 1, MAX_VERTS + 3);
        else if (kind < 20)
            n = MAX_VERTS;
        else
            n = $urandom_range(MIN_VERTS, 8);
        xmode = $urandom_range(0, 2);
        ymode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            face_x = {face_x, pick_coord(xmode)};
            face_y = {face_y, pick_coord(ymode)};
        end
        send_face();
    endtask

    initial
    begin
        int hold;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (out_quiet > 0) begin
                out_quiet--;
                hold = 0;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    out_quiet = $urandom_range(4, 24);
                hold = $urandom_range(0, 12);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        int sent, n;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counter-clockwise at the coordinate extremes: reversed
        face_x = '{C_MIN, C_MAX, C_MIN};
        face_y = '{C_MIN, C_MIN, C_MAX};
        send_face();
        // collinear: zero area keeps load order
        face_x = '{0, 1, 2};
        face_y = '{0, 1, 2};
        send_face();
        // lone vertex: rejected
        face_x = '{-1};
        face_y = '{-1};
        send_face();
        // square with a tie on the lowest edge
        face_x = '{0, 5, 5, 0};
        face_y = '{0, 0, 5, 5};
        send_face();
        // one vertex past capacity
        for (int i = 0; i <= MAX_VERTS; i++) begin
            face_x = {face_x, coord_t'(i)};
            face_y = {face_y, coord_t'(-i)};
        end
        send_face();

        while (sent < RANDOM_WORDS) begin
            random_face(n);
            sent += n;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ polygon_orientation_normalizer.f @@
sv/pon_pkg.sv
sv/pon_ram.sv
sv/pon_cross.sv
sv/polygon_orientation_normalizer.sv
bench/pon_checker.sv
bench/tb_polygon_orientation_normalizer.sv
